### sv/thti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thti_pkg
// Shared constants, types and elaboration-time table builders for the tanh
// cubic Hermite table interpolation unit.
// ----------------------------------------------------------------------------
package thti_pkg;

  localparam int TableEntriesDef = 1024;
  localparam int FracBitsDef     = 16;

  localparam logic signed [15:0] XOneQ = 16'sd4096;

  localparam longint Q30One   = longint'(1) << 30;
  localparam int     ExpTerms = 24;

  typedef struct packed {
    logic               clamped;
    logic signed [15:0] cval;
  } side_t;

  // shift-subtract division, used only on constants during elaboration
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh at table point i of n, Q1.15
  function automatic int rom_value(int i, int n);
    longint span;
    longint m;
    longint a;
    longint u;
    longint term;
    longint sum;
    longint prod;
    longint mag;
    longint e;
    longint t;
    longint q;
    logic   neg;
    span = longint'(n) - 1;
    m    = 2 * longint'(i) - span;
    neg  = m < 0;
    a    = neg ? -m : m;
    u    = longint'(udiv(longint'(a << 31), span));
    term = Q30One;
    sum  = term;
    for (int k = 1; k <= ExpTerms; k++) begin
      prod = term * u;
      mag  = longint'(udiv((prod < 0) ? -prod : prod, longint'(k) * Q30One));
      term = (prod < 0) ? mag : -mag;
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q30One) begin
      sum = Q30One;
    end
    e = sum;
    t = longint'(udiv((Q30One - e) << 30, Q30One + e));
    q = (t + (longint'(1) << 14)) >>> 15;
    return neg ? -int'(q) : int'(q);
  endfunction

  // derivative 1 - f^2, unsigned Q1.15
  function automatic int rom_slope(int f);
    int sq;
    sq = f * f;
    return 32768 - ((sq + 16384) >>> 15);
  endfunction

endpackage

### sv/tanh_hermite_table_interp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_hermite_table_interp_unit
// Streaming tanh for signed Q4.12 samples, result in signed Q1.15. Inputs in
// (-1, 1) are interpolated with a cubic Hermite spline over a table of tanh
// values and slopes; inputs at or beyond the limits return the end entries.
//
// Usage: a sample request enters on in_valid_i / in_ready_o with sample_in_i;
// the result leaves on out_valid_o / out_ready_i with tanh_out_o and
// clamped_o, in the same order. The unit takes one sample every clock while
// out_valid_o is not held back by out_ready_i: ten register stages
// (index multiply, fraction squares with table address, basis weights with
// table read, weighted products, sums, two reciprocal partial products,
// quotient, back multiply, quotient check, rounding with saturation into the
// output register). When out_ready_i is low with a result held, the whole
// pipeline freezes, empty stages included, and in_ready_o drops in the same
// cycle. Reset clears the valid bits only; the tables are constant logic and
// need no fill.
// ----------------------------------------------------------------------------
module tanh_hermite_table_interp_unit #(
  parameter int TableEntries = thti_pkg::TableEntriesDef,
  parameter int FracBits     = thti_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] tanh_out_o,
  output logic               clamped_o
);
  import thti_pkg::*;

  localparam int NumStg = 10;
  localparam int AW     = $clog2(TableEntries);
  localparam int PW     = 13 + AW;
  localparam int Den    = TableEntries - 1;
  localparam int F      = FracBits;
  localparam int W      = F + 15;
  localparam int LoW    = W / 2;
  localparam int HiW    = W - LoW;
  localparam int AccW   = F + 20;
  localparam int ResW   = AccW - F;

  localparam logic [F:0]   OneQ   = (F + 1)'(1) << F;
  localparam logic [F+1:0] ThreeQ = (F + 2)'(3) << F;
  localparam logic [W-1:0] RecipM = W'((longint'(1) << W) / Den);
  localparam logic signed [AccW-1:0] RoundQ = AccW'(1) << (F - 1);
  localparam logic signed [15:0] ClampLo = 16'(rom_value(0, TableEntries));
  localparam logic signed [15:0] ClampHi = 16'(rom_value(TableEntries - 1, TableEntries));
  localparam logic signed [ResW-1:0] SatHi = ResW'(32767);
  localparam logic signed [ResW-1:0] SatLo = -ResW'(32768);

  // constant tables
  logic signed [15:0] val_rom   [TableEntries];
  logic        [15:0] slope_rom [TableEntries];

  for (genvar g = 0; g < TableEntries; g++) begin : g_rom
    localparam int Val = rom_value(g, TableEntries);
    assign val_rom[g]   = 16'(Val);
    assign slope_rom[g] = 16'(rom_slope(Val));
  end

  // flow control
  logic              adv;
  logic [NumStg-1:0] vld_q;
  side_t             side_q [NumStg-1];
  side_t             side_d;

  assign adv        = out_ready_i | ~vld_q[NumStg-1];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  // stage 1: clamp decision and table position
  logic          clamp_lo;
  logic          clamp_hi;
  logic [12:0]   xo;
  logic [PW-1:0] p1_d;
  logic [PW-1:0] p1_q;

  assign clamp_lo       = sample_in_i <= -XOneQ;
  assign clamp_hi       = sample_in_i >= XOneQ;
  assign xo             = sample_in_i[12:0] + 13'(XOneQ);
  assign p1_d           = PW'(xo) * PW'(Den);
  assign side_d.clamped = clamp_lo | clamp_hi;
  assign side_d.cval    = clamp_lo ? ClampLo : ClampHi;

  // stage 2: index, fraction and squares
  logic [AW-1:0]     idx_d;
  logic [12+F:0]     fr_ext;
  logic [F-1:0]      t_d;
  logic [F:0]        v_d;
  logic [2*F+1:0]    vv_p;
  logic [2*F-1:0]    tt_p;
  logic [AW-1:0]     idx_q;
  logic [F-1:0]      t_q;
  logic [F:0]        v_q;
  logic [F:0]        vv_q;
  logic [F-1:0]      tt_q;

  assign idx_d  = p1_q[PW-1:13];
  assign fr_ext = {p1_q[12:0], {F{1'b0}}};
  assign t_d    = fr_ext[12+F:13];
  assign v_d    = OneQ - (F + 1)'(t_d);
  assign vv_p   = (2 * F + 2)'(v_d) * (2 * F + 2)'(v_d);
  assign tt_p   = (2 * F)'(t_d) * (2 * F)'(t_d);

  // stage 3: basis weights and table read
  logic [AW-1:0]  idx_nx;
  logic [F+1:0]   w00;
  logic [F+1:0]   w01;
  logic [2*F+2:0] h00_p;
  logic [2*F:0]   h10_p;
  logic [2*F+1:0] h01_p;
  logic [2*F:0]   h11_p;
  logic [F:0]     h00_q;
  logic [F-1:0]   h10_q;
  logic [F:0]     h01_q;
  logic [F-1:0]   h11_q;
  logic signed [15:0] fa_q;
  logic signed [15:0] fb_q;
  logic [15:0]        da_q;
  logic [15:0]        db_q;

  assign idx_nx = idx_q + AW'(1);
  assign w00    = (F + 2)'(OneQ) + (F + 2)'({t_q, 1'b0});
  assign w01    = ThreeQ - (F + 2)'({t_q, 1'b0});
  assign h00_p  = (2 * F + 3)'(w00) * (2 * F + 3)'(vv_q);
  assign h10_p  = (2 * F + 1)'(t_q) * (2 * F + 1)'(vv_q);
  assign h01_p  = (2 * F + 2)'(w01) * (2 * F + 2)'(tt_q);
  assign h11_p  = (2 * F + 1)'(tt_q) * (2 * F + 1)'(v_q);

  // stage 4: weighted products
  logic signed [F+17:0] pf0_d;
  logic signed [F+17:0] pf1_d;
  logic [F+15:0]        pd0_d;
  logic [F+15:0]        pd1_d;
  logic signed [F+17:0] pf0_q;
  logic signed [F+17:0] pf1_q;
  logic [F+15:0]        pd0_q;
  logic [F+15:0]        pd1_q;

  assign pf0_d = (F + 18)'($signed({1'b0, h00_q})) * (F + 18)'(fa_q);
  assign pf1_d = (F + 18)'($signed({1'b0, h01_q})) * (F + 18)'(fb_q);
  assign pd0_d = (F + 16)'(h10_q) * (F + 16)'(da_q);
  assign pd1_d = (F + 16)'(h11_q) * (F + 16)'(db_q);

  // stage 5: value sum and slope difference magnitude
  logic signed [F+16:0] s_d;
  logic [F+16:0]        mag_d;
  logic signed [AccW-1:0] base_d;
  logic signed [AccW-1:0] base5_q;
  logic [W-1:0]           a5_q;
  logic                   neg5_q;

  assign s_d    = $signed({1'b0, pd0_q}) - $signed({1'b0, pd1_q});
  assign mag_d  = s_d[F+16] ? (F + 17)'(-s_d) : (F + 17)'(s_d);
  assign base_d = AccW'(pf0_q) + AccW'(pf1_q) + RoundQ;

  // stage 6: reciprocal partial products
  logic [HiW+W-1:0]       pph_q;
  logic [LoW+W-1:0]       ppl_q;
  logic [W-1:0]           a6_q;
  logic                   neg6_q;
  logic signed [AccW-1:0] base6_q;

  // stage 7: quotient estimate
  logic [2*W-1:0]         prod_d;
  logic [W-1:0]           q07_q;
  logic [W-1:0]           a7_q;
  logic                   neg7_q;
  logic signed [AccW-1:0] base7_q;

  assign prod_d = ((2 * W)'(pph_q) << LoW) + (2 * W)'(ppl_q);

  // stage 8: back multiply
  logic [2*W-1:0]         qd_p;
  logic [W-1:0]           qd8_q;
  logic [W-1:0]           q08_q;
  logic [W-1:0]           a8_q;
  logic                   neg8_q;
  logic signed [AccW-1:0] base8_q;

  assign qd_p = (2 * W)'(q07_q) * (2 * W)'(Den);

  // stage 9: quotient correction and sign
  logic [W-1:0]           rem_d;
  logic [W-1:0]           q_d;
  logic signed [W:0]      div_d;
  logic signed [W:0]      div9_q;
  logic signed [AccW-1:0] base9_q;

  assign rem_d = a8_q - qd8_q;
  assign q_d   = q08_q + W'(rem_d >= W'(Den));
  assign div_d = neg8_q ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});

  // stage 10: round, saturate, select
  logic signed [AccW-1:0] acc_d;
  logic signed [ResW-1:0] res_d;
  logic signed [15:0]     sat_d;
  logic signed [15:0]     tanh_q;
  logic                   clamped_q;

  assign acc_d = base9_q + AccW'(div9_q);
  assign res_d = acc_d[AccW-1:F];

  always_comb begin
    if (res_d > SatHi) begin
      sat_d = 16'sd32767;
    end else if (res_d < SatLo) begin
      sat_d = -16'sd32768;
    end else begin
      sat_d = 16'(res_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NumStg - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
      p1_q    <= p1_d;
      idx_q   <= idx_d;
      t_q     <= t_d;
      v_q     <= v_d;
      vv_q    <= vv_p[2*F:F];
      tt_q    <= tt_p[2*F-1:F];
      h00_q   <= h00_p[2*F:F];
      h10_q   <= h10_p[2*F-1:F];
      h01_q   <= h01_p[2*F:F];
      h11_q   <= h11_p[2*F-1:F];
      fa_q    <= val_rom[idx_q];
      fb_q    <= val_rom[idx_nx];
      da_q    <= slope_rom[idx_q];
      db_q    <= slope_rom[idx_nx];
      pf0_q   <= pf0_d;
      pf1_q   <= pf1_d;
      pd0_q   <= pd0_d;
      pd1_q   <= pd1_d;
      base5_q <= base_d;
      a5_q    <= {mag_d[F+13:0], 1'b0};
      neg5_q  <= s_d[F+16];
      pph_q   <= (HiW + W)'(a5_q[W-1:LoW]) * (HiW + W)'(RecipM);
      ppl_q   <= (LoW + W)'(a5_q[LoW-1:0]) * (LoW + W)'(RecipM);
      a6_q    <= a5_q;
      neg6_q  <= neg5_q;
      base6_q <= base5_q;
      q07_q   <= prod_d[2*W-1:W];
      a7_q    <= a6_q;
      neg7_q  <= neg6_q;
      base7_q <= base6_q;
      qd8_q   <= qd_p[W-1:0];
      q08_q   <= q07_q;
      a8_q    <= a7_q;
      neg8_q  <= neg7_q;
      base8_q <= base7_q;
      div9_q  <= div_d;
      base9_q <= base8_q;
      tanh_q    <= side_q[NumStg-2].clamped ? side_q[NumStg-2].cval : sat_d;
      clamped_q <= side_q[NumStg-2].clamped;
    end
  end

  assign out_valid_o = vld_q[NumStg-1];
  assign tanh_out_o  = tanh_q;
  assign clamped_o   = clamped_q;

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> (tanh_out_o == ClampLo) || (tanh_out_o == ClampHi))
    else $error("clamped result is not an end entry");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at stage one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[NumStg-2]))
    else $error("result appeared without a request behind it");

endmodule
